// File: sv/deq_pkg.sv
// Shared types and codes for the double-ended queue.
// Holds the transaction structs, command and status codes, controller states
// and the command/status bundles between controller and datapath. No dependencies.
package deq_pkg;

   localparam int NAME_W  = 48;
   localparam int COUNT_W = 5;

   localparam logic [2:0] CMD_PUSH_FRONT = 3'd0;
   localparam logic [2:0] CMD_POP_FRONT  = 3'd1;
   localparam logic [2:0] CMD_PUSH_BACK  = 3'd2;
   localparam logic [2:0] CMD_POP_BACK   = 3'd3;
   localparam logic [2:0] CMD_LIST_ALL   = 3'd4;

   localparam logic [1:0] STAT_OK    = 2'd0;
   localparam logic [1:0] STAT_EMPTY = 2'd1;
   localparam logic [1:0] STAT_FULL  = 2'd2;

   typedef struct packed {
      logic [2:0]        command;
      logic [NAME_W-1:0] name_chars;
   } req_type;

   typedef struct packed {
      logic [NAME_W-1:0]  entry_value;
      logic [1:0]         status;
      logic               last_of_run;
      logic [COUNT_W-1:0] entry_count;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_POP,
      ST_LIST
   } deq_state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic       push_front;
      logic       push_back;
      logic       pop_front;
      logic       pop_back;
      logic       list_start;
      logic       list_issue;
      logic       load_data;
      logic       load_status;
      logic [1:0] status_code;
   } deq_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic full;
      logic empty;
      logic out_free;
      logic rd_pend;
      logic rd_last;
      logic list_more;
   } deq_stat_type;

endpackage

// File: sv/deq_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Read data holds its value in cycles without a read. No dependencies.
module deq_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: sv/deq_ctrl.sv
// Controller state machine of the double-ended queue.
// Decodes accepted commands and sequences pops and listings; uses deq_pkg.
module deq_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic [2:0]            req_command,
   output logic                  req_stall,
   input  deq_pkg::deq_stat_type stat,
   output deq_pkg::deq_cmd_type  cmd
);

   import deq_pkg::*;

   deq_state_type state_ff;
   deq_state_type state_in;
   logic          accept;

   assign accept = (state_ff == ST_IDLE) && req_valid && stat.out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if ((req_command == CMD_POP_FRONT || req_command == CMD_POP_BACK)
                   && !stat.empty) begin
                  state_in = ST_POP;
               end else if (req_command == CMD_LIST_ALL && !stat.empty) begin
                  state_in = ST_LIST;
               end
            end
         end
         ST_POP: begin
            if (stat.rd_pend && stat.out_free) begin
               state_in = ST_IDLE;
            end
         end
         ST_LIST: begin
            if (stat.rd_pend && stat.out_free && stat.rd_last) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Outputs.
   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall = !stat.out_free;
            if (accept) begin
               case (req_command)
                  CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
                     cmd.load_status = 1'b1;
                     if (stat.full) begin
                        cmd.status_code = STAT_FULL;
                     end else begin
                        cmd.status_code = STAT_OK;
                        cmd.push_front  = (req_command == CMD_PUSH_FRONT);
                        cmd.push_back   = (req_command == CMD_PUSH_BACK);
                     end
                  end
                  CMD_POP_FRONT, CMD_POP_BACK: begin
                     if (stat.empty) begin
                        cmd.load_status = 1'b1;
                        cmd.status_code = STAT_EMPTY;
                     end else begin
                        cmd.pop_front = (req_command == CMD_POP_FRONT);
                        cmd.pop_back  = (req_command == CMD_POP_BACK);
                     end
                  end
                  CMD_LIST_ALL: begin
                     if (stat.empty) begin
                        cmd.load_status = 1'b1;
                        cmd.status_code = STAT_EMPTY;
                     end else begin
                        cmd.list_start = 1'b1;
                     end
                  end
                  default: begin
                     // Unused codes are taken and dropped without a result.
                  end
               endcase
            end
         end
         ST_POP: begin
            cmd.load_data = stat.rd_pend && stat.out_free;
         end
         ST_LIST: begin
            cmd.load_data  = stat.rd_pend && stat.out_free;
            // A new read may go out once the previous one has been consumed.
            cmd.list_issue = stat.list_more &&
                             (!stat.rd_pend || (stat.rd_pend && stat.out_free));
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

endmodule

// File: sv/deq_dp.sv
// Datapath of the double-ended queue: ring pointers, entry count, entry
// store and the result register. Uses deq_pkg and deq_ram.
module deq_dp #(
   parameter int QUEUE_DEPTH = 16,
   parameter int NAME_BYTES  = 6
) (
   input  logic                  clock,
   input  logic                  reset,
   input  deq_pkg::req_type      req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output deq_pkg::rsp_type      rsp_data,
   input  deq_pkg::deq_cmd_type  cmd,
   output deq_pkg::deq_stat_type stat
);

   import deq_pkg::*;

   localparam int PW = $clog2(QUEUE_DEPTH);
   localparam int CW = $clog2(QUEUE_DEPTH + 1);
   localparam int SW = PW + 1;
   localparam int NW = 8 * NAME_BYTES;

   logic [PW-1:0] front_ff, front_in;
   logic [CW-1:0] count_ff, count_in;
   logic [PW-1:0] list_ptr_ff, list_ptr_in;
   logic [CW-1:0] list_left_ff, list_left_in;
   logic          rd_pend_ff, rd_pend_in;
   logic          rd_last_ff, rd_last_in;
   logic          out_valid_ff, out_valid_in;
   rsp_type       out_data_ff, out_data_in;

   logic [SW-1:0] back_sum;
   logic [SW-1:0] tail_sum;
   logic [PW-1:0] back_slot;
   logic [PW-1:0] tail_slot;
   logic [PW-1:0] front_dec;
   logic [PW-1:0] front_inc;
   logic [PW-1:0] list_ptr_inc;

   logic          wr_en;
   logic [PW-1:0] wr_addr;
   logic          rd_en;
   logic [PW-1:0] rd_addr;
   logic [NW-1:0] rd_data;

   assign back_sum  = SW'(front_ff) + SW'(count_ff);
   assign tail_sum  = back_sum - SW'(1);
   assign back_slot = (back_sum >= SW'(QUEUE_DEPTH)) ? PW'(back_sum - SW'(QUEUE_DEPTH))
                                                     : PW'(back_sum);
   assign tail_slot = (tail_sum >= SW'(QUEUE_DEPTH)) ? PW'(tail_sum - SW'(QUEUE_DEPTH))
                                                     : PW'(tail_sum);
   assign front_dec    = (front_ff == '0) ? PW'(QUEUE_DEPTH - 1) : front_ff - PW'(1);
   assign front_inc    = (front_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : front_ff + PW'(1);
   assign list_ptr_inc = (list_ptr_ff == PW'(QUEUE_DEPTH - 1)) ? '0
                                                               : list_ptr_ff + PW'(1);

   assign wr_en   = cmd.push_front || cmd.push_back;
   assign wr_addr = cmd.push_front ? front_dec : back_slot;

   assign rd_en = cmd.pop_front || cmd.pop_back || cmd.list_issue;
   always_comb begin
      if (cmd.pop_front) begin
         rd_addr = front_ff;
      end else if (cmd.pop_back) begin
         rd_addr = tail_slot;
      end else begin
         rd_addr = list_ptr_ff;
      end
   end

   deq_ram #(
      .WIDTH (NW),
      .DEPTH (QUEUE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_data.name_chars[NW-1:0]),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      front_in     = front_ff;
      count_in     = count_ff;
      list_ptr_in  = list_ptr_ff;
      list_left_in = list_left_ff;
      rd_pend_in   = rd_pend_ff;
      rd_last_in   = rd_last_ff;

      if (cmd.push_front) begin
         front_in = front_dec;
         count_in = count_ff + CW'(1);
      end else if (cmd.push_back) begin
         count_in = count_ff + CW'(1);
      end else if (cmd.pop_front) begin
         front_in = front_inc;
         count_in = count_ff - CW'(1);
      end else if (cmd.pop_back) begin
         count_in = count_ff - CW'(1);
      end

      if (cmd.list_start) begin
         list_ptr_in  = front_ff;
         list_left_in = count_ff;
      end else if (cmd.list_issue) begin
         list_ptr_in  = list_ptr_inc;
         list_left_in = list_left_ff - CW'(1);
      end

      if (cmd.pop_front || cmd.pop_back) begin
         rd_pend_in = 1'b1;
         rd_last_in = 1'b1;
      end else if (cmd.list_issue) begin
         rd_pend_in = 1'b1;
         rd_last_in = (list_left_ff == CW'(1));
      end else if (cmd.load_data) begin
         rd_pend_in = 1'b0;
      end
   end

   // Result register: a finished result waits here until it is taken.
   always_comb begin
      out_data_in = out_data_ff;
      if (cmd.load_status) begin
         out_data_in.entry_value = '0;
         out_data_in.status      = cmd.status_code;
         out_data_in.last_of_run = 1'b1;
         out_data_in.entry_count = COUNT_W'(count_in);
      end else if (cmd.load_data) begin
         out_data_in.entry_value = NAME_W'(rd_data);
         out_data_in.status      = STAT_OK;
         out_data_in.last_of_run = rd_last_ff;
         out_data_in.entry_count = COUNT_W'(count_ff);
      end
   end

   assign out_valid_in = (cmd.load_status || cmd.load_data) ? 1'b1
                                                            : (out_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff     <= '0;
         count_ff     <= '0;
         list_left_ff <= '0;
         rd_pend_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         front_ff     <= front_in;
         count_ff     <= count_in;
         list_left_ff <= list_left_in;
         rd_pend_ff   <= rd_pend_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      list_ptr_ff <= list_ptr_in;
      rd_last_ff  <= rd_last_in;
      out_data_ff <= out_data_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   assign stat.full      = (count_ff == CW'(QUEUE_DEPTH));
   assign stat.empty     = (count_ff == '0);
   assign stat.out_free  = !out_valid_ff || !rsp_stall;
   assign stat.rd_pend   = rd_pend_ff;
   assign stat.rd_last   = rd_last_ff;
   assign stat.list_more = (list_left_ff != '0);

endmodule

// File: sv/double_ended_queue.sv
// Bounded double-ended queue of short names held in a ring buffer of QUEUE_DEPTH
// entries. Each request transaction pushes or pops at the front or back, or lists
// all entries front to back. A push or a refused command (full, empty) yields
// its single result one cycle after acceptance and the next request may be taken
// at once. A pop reads the entry store on acceptance and loads the registered
// read data in ST_POP. A listing of N entries yields N results, the first after
// the walk set-up and a registered read, then one per cycle while responses are
// not stalled; no request is taken until its last result is loaded. A waiting
// result sits in an output register, so a stalled response side stalls requests
// only while that register is full. The entry store is not cleared at reset.
// Depends on deq_pkg, deq_ctrl, deq_dp and deq_ram.
module double_ended_queue #(
   parameter int QUEUE_DEPTH = 16,
   parameter int NAME_BYTES  = 6
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  deq_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output deq_pkg::rsp_type rsp_data
);

   import deq_pkg::*;

   deq_cmd_type  cmd;
   deq_stat_type stat;

   deq_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_command (req_data.command),
      .req_stall   (req_stall),
      .stat        (stat),
      .cmd         (cmd)
   );

   deq_dp #(
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .NAME_BYTES  (NAME_BYTES)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .cmd       (cmd),
      .stat      (stat)
   );

endmodule

// File: tb/sv/deq_monitor.sv
// Watches the request and response channels of the double-ended queue, predicts
// every response from its own model of the ring buffer and compares field by field.
// Depends on deq_pkg for the transaction structs and the command and status codes.
module deq_monitor #(
   parameter int QUEUE_DEPTH = 16,
   parameter int NAME_BYTES  = 6
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_stall,
   input  deq_pkg::req_type req_data,
   input  logic             rsp_valid,
   input  logic             rsp_stall,
   input  deq_pkg::rsp_type rsp_data,
   output int               failures,
   output int               pending
);
   import deq_pkg::*;

   localparam logic [NAME_W-1:0] NAME_MASK = (NAME_BYTES >= 6) ? {NAME_W{1'b1}} :
                                             ((48'd1 << (8 * NAME_BYTES)) - 48'd1);

   logic [NAME_W-1:0] shadow_store [QUEUE_DEPTH];
   int                shadow_front;
   int                shadow_count;
   rsp_type           awaited_results [$];

   initial begin
      failures = 0;
      pending  = 0;
   end

   function automatic rsp_type make_result(logic [NAME_W-1:0] value, logic [1:0] status,
                                           logic last);
      rsp_type r;
      r.entry_value = value;
      r.status      = status;
      r.last_of_run = last;
      r.entry_count = COUNT_W'(shadow_count);
      return r;
   endfunction

   task automatic report_mismatch(string what, logic [NAME_W-1:0] got,
                                  logic [NAME_W-1:0] want);
      $display("ERROR at %0t: %s: got %h, expected %h", $realtime, what, got, want);
      failures++;
   endtask

   // Updates the shadow queue for one accepted request transaction and queues
   // the responses it ought to produce.
   task automatic predict_request(req_type item);
      logic [NAME_W-1:0] kept;
      int                slot;
      kept = item.name_chars & NAME_MASK;
      case (item.command)
         CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
            if (shadow_count >= QUEUE_DEPTH) begin
               awaited_results.push_back(make_result('0, STAT_FULL, 1'b1));
            end else begin
               if (item.command == CMD_PUSH_FRONT) begin
                  shadow_front = (shadow_front + QUEUE_DEPTH - 1) % QUEUE_DEPTH;
                  slot = shadow_front;
               end else begin
                  slot = (shadow_front + shadow_count) % QUEUE_DEPTH;
               end
               shadow_store[slot] = kept;
               shadow_count++;
               awaited_results.push_back(make_result('0, STAT_OK, 1'b1));
            end
         end
         CMD_POP_FRONT, CMD_POP_BACK: begin
            if (shadow_count == 0) begin
               awaited_results.push_back(make_result('0, STAT_EMPTY, 1'b1));
            end else begin
               if (item.command == CMD_POP_FRONT) begin
                  slot = shadow_front;
                  shadow_front = (shadow_front + 1) % QUEUE_DEPTH;
               end else begin
                  slot = (shadow_front + shadow_count - 1) % QUEUE_DEPTH;
               end
               shadow_count--;
               awaited_results.push_back(make_result(shadow_store[slot], STAT_OK, 1'b1));
            end
         end
         CMD_LIST_ALL: begin
            if (shadow_count == 0) begin
               awaited_results.push_back(make_result('0, STAT_EMPTY, 1'b1));
            end else begin
               for (int i = 0; i < shadow_count; i++) begin
                  slot = (shadow_front + i) % QUEUE_DEPTH;
                  awaited_results.push_back(make_result(shadow_store[slot], STAT_OK,
                                                        i == shadow_count - 1));
               end
            end
         end
         default: ;
      endcase
   endtask

   task automatic check_result(rsp_type got);
      rsp_type want;
      if (awaited_results.size() == 0) begin
         report_mismatch("response with none outstanding, entry", got.entry_value, '0);
      end else begin
         want = awaited_results.pop_front();
         if (got.entry_value !== want.entry_value)
            report_mismatch("entry_value", got.entry_value, want.entry_value);
         if (got.status !== want.status)
            report_mismatch("status", NAME_W'(got.status), NAME_W'(want.status));
         if (got.last_of_run !== want.last_of_run)
            report_mismatch("last_of_run", NAME_W'(got.last_of_run), NAME_W'(want.last_of_run));
         if (got.entry_count !== want.entry_count)
            report_mismatch("entry_count", NAME_W'(got.entry_count), NAME_W'(want.entry_count));
      end
   endtask

   // A response can never follow its request in the same cycle, so checking
   // before predicting keeps the order of the expectations intact.
   always @(posedge clock) begin
      if (reset) begin
         shadow_front = 0;
         shadow_count = 0;
         awaited_results.delete();
      end else begin
         if (rsp_valid && !rsp_stall) check_result(rsp_data);
         if (req_valid && !req_stall) predict_request(req_data);
      end
      pending = awaited_results.size();
   end

endmodule

// File: tb/sv/double_ended_queue_tb.sv
// Top of the double-ended queue testbench: clock, reset, request stimulus and
// response back-pressure, with the verdict taken from deq_monitor.
// Depends on deq_pkg, deq_monitor and double_ended_queue.
module double_ended_queue_tb;
   import deq_pkg::*;

   localparam logic [2:0] CMD_UNUSED_FIRST = 3'd5;
   localparam logic [2:0] CMD_UNUSED_LAST  = 3'd7;
   localparam int         RANDOM_ITEMS     = 400;

   typedef enum int {
      MIX_BALANCED,
      MIX_FILLING,
      MIX_DRAINING
   } mix_type;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;
   int      failures;
   int      pending;
   int      req_gap_max = 3;
   int      rsp_gap_max = 3;

   double_ended_queue #(
      .QUEUE_DEPTH(16),
      .NAME_BYTES (6)
   ) uut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data)
   );

   deq_monitor #(
      .QUEUE_DEPTH(16),
      .NAME_BYTES (6)
   ) result_watch (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data),
      .failures (failures),
      .pending  (pending)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   initial begin
      #2000000;
      $display("Test completed with failures");
      $finish;
   end

   function automatic req_type make_request(logic [2:0] command, logic [NAME_W-1:0] name);
      req_type r;
      r.command    = command;
      r.name_chars = name;
      return r;
   endfunction

   function automatic logic [NAME_W-1:0] random_name();
      int pick;
      pick = $urandom_range(0, 7);
      if (pick == 0) return '0;
      if (pick == 1) return '1;
      return {16'($urandom()), 32'($urandom())};
   endfunction

   // Pushes dominate while filling and pops while draining, so the queue
   // regularly reaches both full and empty.
   function automatic req_type random_request(mix_type mix);
      int         pick;
      int         push_limit;
      int         pop_limit;
      logic [2:0] command;
      pick = $urandom_range(0, 99);
      case (mix)
         MIX_FILLING: begin
            push_limit = 65;
            pop_limit  = 80;
         end
         MIX_DRAINING: begin
            push_limit = 15;
            pop_limit  = 85;
         end
         default: begin
            push_limit = 45;
            pop_limit  = 80;
         end
      endcase
      if (pick < push_limit)
         command = $urandom_range(0, 1) ? CMD_PUSH_FRONT : CMD_PUSH_BACK;
      else if (pick < pop_limit)
         command = $urandom_range(0, 1) ? CMD_POP_FRONT : CMD_POP_BACK;
      else if (pick < 97)
         command = CMD_LIST_ALL;
      else
         command = 3'($urandom_range(CMD_UNUSED_FIRST, CMD_UNUSED_LAST));
      return make_request(command, random_name());
   endfunction

   // Drives one request transaction and returns at the falling edge after it
   // has been accepted.
   task automatic send_request(req_type item);
      int gap;
      gap = $urandom_range(0, req_gap_max);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   // Response side: a random stall before each transaction.
   initial begin
      int hold;
      forever begin
         hold = $urandom_range(0, rsp_gap_max);
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(negedge clock);
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         @(negedge clock);
      end
   end

   initial begin
      mix_type mix;
      req_type item;
      int      counted;
      repeat (8) @(negedge clock);
      reset <= 1'b0;

      // Empty queue, a three-entry listing, single-entry pops from either end and the ignored codes.
      send_request(make_request(CMD_LIST_ALL,   48'h0));
      send_request(make_request(CMD_POP_FRONT,  48'h0));
      send_request(make_request(CMD_POP_BACK,   48'h0));
      send_request(make_request(CMD_PUSH_FRONT, 48'h0));
      send_request(make_request(CMD_PUSH_BACK,  48'hFFFF_FFFF_FFFF));
      send_request(make_request(CMD_PUSH_FRONT, 48'h5A5A_A5A5_0F0F));
      send_request(make_request(CMD_LIST_ALL,   48'h0));
      send_request(make_request(CMD_POP_BACK,   48'h0));
      send_request(make_request(CMD_POP_FRONT,  48'h0));
      send_request(make_request(CMD_POP_FRONT,  48'h0));
      send_request(make_request(CMD_POP_BACK,   48'h0));
      send_request(make_request(CMD_PUSH_BACK,  48'h8000_0000_0001));
      send_request(make_request(CMD_POP_BACK,   48'h0));
      for (int c = CMD_UNUSED_FIRST; c <= CMD_UNUSED_LAST; c++)
         send_request(make_request(3'(c), 48'hFFFF_FFFF_FFFF));
      send_request(make_request(CMD_LIST_ALL,   48'h0));

      mix     = MIX_FILLING;
      counted = 0;
      while (counted < RANDOM_ITEMS) begin
         if (counted % 40 == 0) begin
            mix         = mix_type'($urandom_range(0, 2));
            req_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 3;
            rsp_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 3;
         end
         item = random_request(mix);
         send_request(item);
         if (item.command <= CMD_LIST_ALL) counted++;
      end
      req_valid <= 1'b0;

      while (pending != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (failures == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

// File: double_ended_queue.f
sv/deq_pkg.sv
sv/deq_ram.sv
sv/deq_ctrl.sv
sv/deq_dp.sv
sv/double_ended_queue.sv
tb/sv/deq_monitor.sv
tb/sv/double_ended_queue_tb.sv
